[sv/rpc_retransmit_timer_macros.svh]
// Assertion helpers used by the checker file.
`ifndef RPC_RETRANSMIT_TIMER_MACROS_SVH
`define RPC_RETRANSMIT_TIMER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, quiet during reset.
`define RPCRT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rpcrt: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock, quiet during reset.
`define RPCRT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rpcrt: next-cycle check failed");

`endif

[sv/rpcrt_pkg.sv]
package rpcrt_pkg;

  localparam int unsigned CmdW    = 2;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned WaitW   = 31;
  localparam int unsigned XidW    = 32;
  localparam int unsigned ActW    = 2;
  localparam int unsigned StatW   = 3;
  localparam int unsigned RtoW    = 31;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CfgW    = 32;

  localparam logic [31:0] XidSeedRst  = 32'h1f7391f3;
  localparam logic [15:0] MaxRtoRst   = 16'd16000;
  localparam logic [15:0] FloorRtoRst = 16'd1000;
  localparam logic [7:0]  MaxTriesRst = 8'd18;
  localparam logic [31:0] AvgRst      = 32'd800;
  localparam logic [31:0] DevRst      = 32'd20;
  localparam logic [30:0] RtoRst      = 31'd1000;
  localparam logic [7:0]  TryMax      = 8'd255;

  typedef enum logic [CmdW-1:0] {
    CMD_START = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_REPLY = 2'd2
  } cmd_e;

  typedef enum logic [ActW-1:0] {
    ACT_NONE   = 2'd0,
    ACT_SEND   = 2'd1,
    ACT_RESEND = 2'd2,
    ACT_FINISH = 2'd3
  } action_e;

  typedef enum logic [StatW-1:0] {
    ST_PENDING   = 3'd0,
    ST_SUCCESS   = 3'd1,
    ST_TIMED_OUT = 3'd2,
    ST_EXHAUSTED = 3'd3,
    ST_BUSY      = 3'd4
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_XID_SEED  = 8'd0,
    REG_MAX_RTO   = 8'd1,
    REG_FLOOR_RTO = 8'd2,
    REG_MAX_TRIES = 8'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [CmdW-1:0]  command;
    logic [TimeW-1:0] now_ms;
    logic [WaitW-1:0] wait_ms;
    logic [XidW-1:0]  reply_xid;
  } req_t;

  typedef struct packed {
    logic [ActW-1:0]  action;
    logic [XidW-1:0]  xid_out;
    logic [StatW-1:0] status;
    logic [RtoW-1:0]  rto_now_ms;
  } rsp_t;

  typedef struct packed {
    logic               wr;
    logic [CfgIdxW-1:0] index;
    logic [CfgW-1:0]    data;
  } cfg_wr_t;

endpackage

[sv/rpcrt_ifs.sv]
interface rpcrt_req_if;
  import rpcrt_pkg::*;
  logic             valid;
  logic             ready;
  logic [CmdW-1:0]  command;
  logic [TimeW-1:0] now_ms;
  logic [WaitW-1:0] wait_ms;
  logic [XidW-1:0]  reply_xid;
  modport source (output valid, command, now_ms, wait_ms, reply_xid, input ready);
  modport sink (input valid, command, now_ms, wait_ms, reply_xid, output ready);
endinterface

interface rpcrt_rsp_if;
  import rpcrt_pkg::*;
  logic             valid;
  logic             ready;
  logic [ActW-1:0]  action;
  logic [XidW-1:0]  xid_out;
  logic [StatW-1:0] status;
  logic [RtoW-1:0]  rto_now_ms;
  modport source (output valid, action, xid_out, status, rto_now_ms, input ready);
  modport sink (input valid, action, xid_out, status, rto_now_ms, output ready);
endinterface

interface rpcrt_cfg_if;
  import rpcrt_pkg::*;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [CfgW-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[sv/rpcrt_estimator.sv]
// Mean-plus-deviation round trip estimator, one update per call.
module rpcrt_estimator (
  input  logic signed [31:0] avg_i,
  input  logic signed [31:0] dev_i,
  input  logic        [31:0] elapsed_i,
  output logic signed [31:0] avg_o,
  output logic signed [31:0] dev_o,
  output logic        [30:0] rto_o
);
  import rpcrt_pkg::*;

  logic signed [31:0] err;
  logic signed [31:0] err_abs;
  logic signed [31:0] dev_err;
  logic signed [31:0] sum;
  logic signed [31:0] est;

  always_comb begin
    err     = $signed(elapsed_i) - (avg_i >>> 3);
    avg_o   = avg_i + err;
    err_abs = err[31] ? -err : err;
    dev_err = err_abs - (dev_i >>> 2);
    dev_o   = dev_i + dev_err;
    sum     = (avg_o >>> 2) + dev_o;
    est     = sum >>> 1;
    // clamp a negative estimate to zero
    rto_o   = est[31] ? '0 : est[30:0];
  end

endmodule

[sv/rpcrt_core.sv]
// Call state, configuration registers and per-item decision logic.
module rpcrt_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  rpcrt_pkg::req_t   req_i,
  input  rpcrt_pkg::cfg_wr_t cfg_i,
  output rpcrt_pkg::rsp_t   rsp_o
);
  import rpcrt_pkg::*;

  logic [15:0]        max_rto_q, floor_rto_q;
  logic [7:0]         max_tries_q;

  logic signed [31:0] avg_q, avg_d, dev_q, dev_d, avg_new, dev_new;
  logic [30:0]        rto_q, rto_d, est_rto;
  logic [31:0]        next_xid_q, next_xid_d, call_xid_q, call_xid_d;
  logic [31:0]        send_q, send_d, retx_dl_q, retx_dl_d, call_dl_q, call_dl_d;
  logic [7:0]         try_q, try_d, try_inc;
  logic               busy_q, busy_d;

  logic [31:0]        elapsed, dbl, floored, capped;
  logic               retx_due, call_over;
  action_e            action;
  status_e            status;

  function automatic logic later(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] diff;
    diff  = a - b;
    later = (diff != '0) && !diff[31];
  endfunction

  rpcrt_estimator u_est (
    .avg_i    (avg_q),
    .dev_i    (dev_q),
    .elapsed_i(elapsed),
    .avg_o    (avg_new),
    .dev_o    (dev_new),
    .rto_o    (est_rto)
  );

  assign elapsed   = req_i.now_ms - send_q;
  assign retx_due  = busy_q && later(req_i.now_ms, retx_dl_q);
  assign call_over = later(req_i.now_ms, call_dl_q);
  assign try_inc   = (try_q == TryMax) ? try_q : try_q + 8'd1;
  assign dbl       = {rto_q, 1'b0};
  assign floored   = ((try_inc > 8'd1) && (dbl < {16'd0, floor_rto_q}))
                     ? {16'd0, floor_rto_q} : dbl;
  assign capped    = (floored > {16'd0, max_rto_q}) ? {16'd0, max_rto_q} : floored;

  always_comb begin
    avg_d      = avg_q;
    dev_d      = dev_q;
    rto_d      = rto_q;
    next_xid_d = next_xid_q;
    call_xid_d = call_xid_q;
    send_d     = send_q;
    retx_dl_d  = retx_dl_q;
    call_dl_d  = call_dl_q;
    try_d      = try_q;
    busy_d     = busy_q;
    action     = ACT_NONE;
    status     = ST_PENDING;
    case (cmd_e'(req_i.command))
      CMD_START: begin
        if (busy_q) begin
          status = ST_BUSY;
        end else begin
          call_xid_d = next_xid_q;
          next_xid_d = next_xid_q + 32'd1;
          send_d     = req_i.now_ms;
          retx_dl_d  = req_i.now_ms + {1'b0, rto_q};
          call_dl_d  = req_i.now_ms + {1'b0, req_i.wait_ms};
          try_d      = '0;
          busy_d     = 1'b1;
          action     = ACT_SEND;
        end
      end
      CMD_TICK: begin
        if (retx_due) begin
          try_d = try_inc;
          if (call_over) begin
            busy_d = 1'b0;
            action = ACT_FINISH;
            status = ST_TIMED_OUT;
          end else begin
            avg_d = avg_new;
            dev_d = dev_new;
            rto_d = capped[30:0];
            if (try_inc >= max_tries_q) begin
              busy_d = 1'b0;
              action = ACT_FINISH;
              status = ST_EXHAUSTED;
            end else begin
              send_d    = req_i.now_ms;
              retx_dl_d = req_i.now_ms + capped;
              action    = ACT_RESEND;
            end
          end
        end
      end
      CMD_REPLY: begin
        if (busy_q) begin
          avg_d = avg_new;
          dev_d = dev_new;
          rto_d = est_rto;
          if (req_i.reply_xid == call_xid_q) begin
            busy_d = 1'b0;
            action = ACT_FINISH;
            status = ST_SUCCESS;
          end
        end
      end
      default: ;
    endcase
  end

  assign rsp_o.action     = action;
  assign rsp_o.xid_out    = call_xid_d;
  assign rsp_o.status     = status;
  assign rsp_o.rto_now_ms = rto_d;

  // the seed itself only loads the id counter below
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_rto_q   <= MaxRtoRst;
      floor_rto_q <= FloorRtoRst;
      max_tries_q <= MaxTriesRst;
    end else if (cfg_i.wr) begin
      unique case (cfg_i.index)
        REG_XID_SEED:  ;
        REG_MAX_RTO:   max_rto_q   <= cfg_i.data[15:0];
        REG_FLOOR_RTO: floor_rto_q <= cfg_i.data[15:0];
        REG_MAX_TRIES: max_tries_q <= cfg_i.data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_q      <= $signed(AvgRst);
      dev_q      <= $signed(DevRst);
      rto_q      <= RtoRst;
      next_xid_q <= XidSeedRst;
      call_xid_q <= '0;
      send_q     <= '0;
      retx_dl_q  <= '0;
      call_dl_q  <= '0;
      try_q      <= '0;
      busy_q     <= 1'b0;
    end else begin
      if (step_i) begin
        avg_q      <= avg_d;
        dev_q      <= dev_d;
        rto_q      <= rto_d;
        call_xid_q <= call_xid_d;
        send_q     <= send_d;
        retx_dl_q  <= retx_dl_d;
        call_dl_q  <= call_dl_d;
        try_q      <= try_d;
        busy_q     <= busy_d;
      end
      // a seed write reloads the id counter
      if (cfg_i.wr && (cfg_i.index == REG_XID_SEED)) begin
        next_xid_q <= cfg_i.data;
      end else if (step_i) begin
        next_xid_q <= next_xid_d;
      end
    end
  end

endmodule

[sv/rpc_retransmit_timer.sv]
// Client-side retransmit timer for a datagram request/reply exchange. Send
// items on req_i: command 0 starts a call (takes the next transaction id and
// arms a retransmit deadline and an overall deadline of now_ms + wait_ms),
// command 1 is a time tick, command 2 reports an arrived reply with its id.
// Every item yields exactly one item on rsp_o: action (nothing, send, resend,
// finished), the current call id, a status (pending, success, timed out,
// tries exhausted, busy) and the retransmit timeout in force after the item.
// Times are milliseconds compared by signed modular difference. One item
// enters per clock unless the input register is held: an item waits in the
// input register, then the call state and the result register update as
// it advances into a free result slot. A result waiting on rsp_o stalls the
// input register only; a new item is still taken while the output drains.
// Write configuration through cfg_i only while no item is in flight:
// index 0 xid seed (also reloads the id counter), 1 timeout cap, 2 timeout
// floor, 3 try limit.
module rpc_retransmit_timer (
  input  logic        clk_i,
  input  logic        rst_ni,
  rpcrt_req_if.sink   req_i,
  rpcrt_rsp_if.source rsp_o,
  rpcrt_cfg_if.sink   cfg_i
);
  import rpcrt_pkg::*;

  logic     in_valid_q;
  req_t     in_q;
  logic     out_valid_q;
  rsp_t     out_q;
  rsp_t     result;
  cfg_wr_t  cfg_wr;
  logic     advance;

  // move the held item through the state update when the result slot frees
  assign advance     = in_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !in_valid_q || advance;
  assign cfg_i.ready = 1'b1;

  assign cfg_wr.wr    = cfg_i.valid;
  assign cfg_wr.index = cfg_i.index;
  assign cfg_wr.data  = cfg_i.data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      in_valid_q <= req_i.valid;
    end
  end

  // hold the payload until it advances
  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      in_q.command   <= req_i.command;
      in_q.now_ms    <= req_i.now_ms;
      in_q.wait_ms   <= req_i.wait_ms;
      in_q.reply_xid <= req_i.reply_xid;
    end
  end

  rpcrt_core u_core (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(advance),
    .req_i (in_q),
    .cfg_i (cfg_wr),
    .rsp_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.action     = out_q.action;
  assign rsp_o.xid_out    = out_q.xid_out;
  assign rsp_o.status     = out_q.status;
  assign rsp_o.rto_now_ms = out_q.rto_now_ms;

endmodule

[sv/rpcrt_checker.sv]
`include "rpc_retransmit_timer_macros.svh"

module rpcrt_checker (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    req_valid_i,
  input logic                    req_ready_i,
  input logic                    rsp_valid_i,
  input logic                    rsp_ready_i,
  input logic [rpcrt_pkg::ActW-1:0]  rsp_action_i,
  input logic [rpcrt_pkg::StatW-1:0] rsp_status_i,
  input logic [rpcrt_pkg::RtoW-1:0]  rsp_rto_i
);
  import rpcrt_pkg::*;

  // a stalled result stays up
  `RPCRT_ASSERT_NXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, rsp_valid_i)
  // a draining output never blocks the input side
  `RPCRT_ASSERT_IMP(a_no_stall, clk_i, rst_ni, rsp_ready_i, req_ready_i)
  // a rejected start carries no action; a finish carries a final status
  `RPCRT_ASSERT_IMP(a_busy_idle, clk_i, rst_ni,
    rsp_valid_i && (rsp_status_i == ST_BUSY) && (req_valid_i || !req_valid_i),
    rsp_action_i == ACT_NONE)
  `RPCRT_ASSERT_IMP(a_finish_stat, clk_i, rst_ni,
    rsp_valid_i && (rsp_action_i == ACT_FINISH),
    (rsp_status_i == ST_SUCCESS) || (rsp_status_i == ST_TIMED_OUT) ||
    (rsp_status_i == ST_EXHAUSTED))
  // after a resend the timeout is capped to a 16-bit value
  `RPCRT_ASSERT_IMP(a_resend_cap, clk_i, rst_ni,
    rsp_valid_i && (rsp_action_i == ACT_RESEND),
    (rsp_rto_i <= 31'd65535) && (rsp_status_i == ST_PENDING))

endmodule

bind rpc_retransmit_timer rpcrt_checker u_rpcrt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_action_i(rsp_o.action),
  .rsp_status_i(rsp_o.status),
  .rsp_rto_i   (rsp_o.rto_now_ms)
);
